// ===== rtl/core/ampd_pkg.sv =====
package ampd_pkg;

   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned Q5_W = 13;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned TIMEOUT_W = 17;
   localparam int unsigned CAL_COUNT_W = 6;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 17;

   localparam logic [2:0] ACT_CALIBRATE = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_SAMPLE = 3'd2;
   localparam logic [2:0] ACT_IDLE = 3'd3;
   localparam logic [2:0] ACT_RESET_EDGE = 3'd4;
   localparam logic [2:0] ACT_ABORT = 3'd5;
   localparam logic [2:0] ACT_SPARE_LOW = 3'd6;
   localparam logic [2:0] ACT_SPARE_HIGH = 3'd7;

   localparam logic [1:0] MODE_EDGE = 2'd0;
   localparam logic [1:0] MODE_GAP = 2'd1;
   localparam logic [1:0] MODE_WAIT = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] ST_NONE = 3'd0;
   localparam logic [2:0] ST_EDGE = 3'd1;
   localparam logic [2:0] ST_GAP = 3'd2;
   localparam logic [2:0] ST_LIMIT = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;
   localparam logic [2:0] ST_ABORTED = 3'd5;
   localparam logic [2:0] ST_CALIBRATED = 3'd6;

   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVIATION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd2;

   localparam logic [Q5_W-1:0] DEVIATION_RESET = 13'd640;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 17'd100000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'hFF;

   typedef struct packed {
      logic [2:0] action;
      logic [SAMPLE_W-1:0] sample;
      logic [COUNT_W-1:0] max_periods;
      logic [1:0] count_mode;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [COUNT_W-1:0] periods;
      logic edge_level;
      logic [SAMPLE_W-1:0] average;
      logic [SAMPLE_W-1:0] minimum;
      logic [SAMPLE_W-1:0] maximum;
   } rsp_type;

endpackage

// ===== rtl/core/adc_mean_edge_period_detector.sv =====
// Carrier ADC sample mean and edge-period detector.
// Request channel (req_valid/req_ready/req_data): one action per request -
// calibrate sample, start count run, sample, idle tick, reset edge or abort.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one response per
// request, carrying status, period count, edge level, mean, min and max.
// CSR port (csr_wr_en/csr_index/csr_wdata): edge mode, deviation (1/32 counts)
// and timeout limit; write only while no request is in flight.
// The response is registered and appears in the cycle after the request is taken.
// One request per cycle while the response register is free or drained; all state
// updates are compares and adds into the state registers and the response register.
// A stalled receiver holds the response register; req_ready stays high while
// the response register is empty or being drained in the same cycle.
// Reset clears the calibration and run state, sets deviation 640 and timeout
// 100000, and empties the response register.
module adc_mean_edge_period_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ampd_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ampd_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [ampd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ampd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic                               edge_mode_ff;
   logic [ampd_pkg::Q5_W-1:0]          deviation_ff;
   logic [ampd_pkg::TIMEOUT_W-1:0]     timeout_limit_ff;

   logic [ampd_pkg::CAL_COUNT_W-1:0]   cal_count_ff, cal_count_in;
   logic [ampd_pkg::Q5_W-1:0]          cal_sum_ff, cal_sum_in;
   logic [ampd_pkg::SAMPLE_W-1:0]      cal_min_ff, cal_min_in;
   logic [ampd_pkg::SAMPLE_W-1:0]      cal_max_ff, cal_max_in;
   logic [ampd_pkg::Q5_W-1:0]          mean_q5_ff, mean_q5_in;
   logic [ampd_pkg::SAMPLE_W-1:0]      mean_whole_ff, mean_whole_in;
   logic [ampd_pkg::SAMPLE_W-1:0]      prior_ff, prior_in;
   logic                               rising_ff, rising_in;
   logic                               run_active_ff, run_active_in;
   logic [1:0]                         run_mode_ff, run_mode_in;
   logic [ampd_pkg::COUNT_W-1:0]       run_limit_ff, run_limit_in;
   logic [ampd_pkg::COUNT_W-1:0]       sample_count_ff, sample_count_in;
   logic [ampd_pkg::TIMEOUT_W-1:0]     idle_left_ff, idle_left_in;

   logic                               rsp_valid_ff;
   ampd_pkg::rsp_type                  rsp_data_ff, rsp_in;
   logic                               accept;

   logic [ampd_pkg::SAMPLE_W-1:0]      base_min, base_max;
   logic [ampd_pkg::Q5_W-1:0]          sum_next;
   logic [ampd_pkg::CAL_COUNT_W-1:0]   cal_count_inc;
   logic [ampd_pkg::Q5_W:0]            peak;
   logic [ampd_pkg::Q5_W-1:0]          trough;
   logic [ampd_pkg::Q5_W-1:0]          s5, p5;
   logic                               edge_hit;
   logic [ampd_pkg::TIMEOUT_W-1:0]     idle_dec;
   logic [ampd_pkg::COUNT_W-1:0]       count_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign base_min = (cal_count_ff == '0) ? ampd_pkg::SAMPLE_MAX : cal_min_ff;
   assign base_max = (cal_count_ff == '0) ? '0 : cal_max_ff;
   assign sum_next = cal_sum_ff + ampd_pkg::Q5_W'(req_data.sample);
   assign cal_count_inc = cal_count_ff + 1'b1;

   assign peak = {1'b0, mean_q5_ff} + {1'b0, deviation_ff};
   assign trough = (mean_q5_ff > deviation_ff) ? (mean_q5_ff - deviation_ff) : '0;
   assign s5 = {req_data.sample, 5'b0};
   assign p5 = {prior_ff, 5'b0};

   always_comb begin
      if (!edge_mode_ff) begin
         if (rising_ff) begin
            edge_hit = ({1'b0, p5} > peak) && (req_data.sample <= prior_ff);
         end else begin
            edge_hit = (p5 < trough) && (req_data.sample >= prior_ff);
         end
      end else begin
         if (rising_ff) begin
            edge_hit = (s5 <= mean_q5_ff) && (s5 <= trough);
         end else begin
            edge_hit = ({1'b0, s5} >= peak);
         end
      end
   end

   assign idle_dec = idle_left_ff - 1'b1;
   assign count_inc = sample_count_ff + 1'b1;

   always_comb begin
      cal_count_in = cal_count_ff;
      cal_sum_in = cal_sum_ff;
      cal_min_in = cal_min_ff;
      cal_max_in = cal_max_ff;
      mean_q5_in = mean_q5_ff;
      mean_whole_in = mean_whole_ff;
      prior_in = prior_ff;
      rising_in = rising_ff;
      run_active_in = run_active_ff;
      run_mode_in = run_mode_ff;
      run_limit_in = run_limit_ff;
      sample_count_in = sample_count_ff;
      idle_left_in = idle_left_ff;
      rsp_in.status = ampd_pkg::ST_NONE;
      rsp_in.periods = '0;

      case (req_data.action)
         ampd_pkg::ACT_CALIBRATE: begin
            cal_min_in = (req_data.sample < base_min) ? req_data.sample : base_min;
            cal_max_in = (req_data.sample > base_max) ? req_data.sample : base_max;
            if (cal_count_inc[ampd_pkg::CAL_COUNT_W-1]) begin
               mean_q5_in = sum_next;
               mean_whole_in = sum_next[ampd_pkg::Q5_W-1:5];
               prior_in = sum_next[ampd_pkg::Q5_W-1:5];
               cal_sum_in = '0;
               cal_count_in = '0;
               rsp_in.status = ampd_pkg::ST_CALIBRATED;
            end else begin
               cal_sum_in = sum_next;
               cal_count_in = cal_count_inc;
            end
         end
         ampd_pkg::ACT_START: begin
            run_active_in = 1'b1;
            run_mode_in = (req_data.count_mode == ampd_pkg::MODE_UNUSED) ?
                          ampd_pkg::MODE_WAIT : req_data.count_mode;
            run_limit_in = req_data.max_periods;
            sample_count_in = '0;
            idle_left_in = timeout_limit_ff;
         end
         ampd_pkg::ACT_SAMPLE, ampd_pkg::ACT_IDLE: begin
            if (run_active_ff) begin
               idle_left_in = idle_dec;
               if (idle_dec == '0) begin
                  run_active_in = 1'b0;
                  rsp_in.status = ampd_pkg::ST_TIMEOUT;
               end else if (req_data.action == ampd_pkg::ACT_SAMPLE) begin
                  sample_count_in = count_inc;
                  idle_left_in = timeout_limit_ff;
                  if (run_mode_ff == ampd_pkg::MODE_GAP && req_data.sample == '0) begin
                     run_active_in = 1'b0;
                     rsp_in.status = ampd_pkg::ST_GAP;
                     rsp_in.periods = count_inc;
                  end else if (run_mode_ff == ampd_pkg::MODE_EDGE && edge_hit) begin
                     rising_in = !rising_ff;
                     run_active_in = 1'b0;
                     rsp_in.status = ampd_pkg::ST_EDGE;
                     rsp_in.periods = count_inc;
                  end else begin
                     prior_in = req_data.sample;
                     if (count_inc >= run_limit_ff) begin
                        run_active_in = 1'b0;
                        rsp_in.status = ampd_pkg::ST_LIMIT;
                     end
                  end
               end
            end
         end
         ampd_pkg::ACT_RESET_EDGE: begin
            rising_in = 1'b0;
            prior_in = ampd_pkg::SAMPLE_MAX;
         end
         ampd_pkg::ACT_ABORT: begin
            if (run_active_ff) begin
               run_active_in = 1'b0;
               rsp_in.status = ampd_pkg::ST_ABORTED;
            end
         end
         default: begin
         end
      endcase

      rsp_in.edge_level = rising_in;
      rsp_in.average = mean_whole_in;
      rsp_in.minimum = cal_min_in;
      rsp_in.maximum = cal_max_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_mode_ff <= 1'b0;
         deviation_ff <= ampd_pkg::DEVIATION_RESET;
         timeout_limit_ff <= ampd_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ampd_pkg::CSR_EDGE_MODE: edge_mode_ff <= csr_wdata[0];
            ampd_pkg::CSR_DEVIATION: deviation_ff <= csr_wdata[ampd_pkg::Q5_W-1:0];
            ampd_pkg::CSR_TIMEOUT:   timeout_limit_ff <= csr_wdata[ampd_pkg::TIMEOUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_count_ff <= '0;
         cal_sum_ff <= '0;
         cal_min_ff <= ampd_pkg::SAMPLE_MAX;
         cal_max_ff <= '0;
         mean_q5_ff <= '0;
         mean_whole_ff <= '0;
         prior_ff <= '0;
         rising_ff <= 1'b0;
         run_active_ff <= 1'b0;
         run_mode_ff <= ampd_pkg::MODE_EDGE;
         run_limit_ff <= '0;
         sample_count_ff <= '0;
         idle_left_ff <= ampd_pkg::TIMEOUT_RESET;
      end else if (accept) begin
         cal_count_ff <= cal_count_in;
         cal_sum_ff <= cal_sum_in;
         cal_min_ff <= cal_min_in;
         cal_max_ff <= cal_max_in;
         mean_q5_ff <= mean_q5_in;
         mean_whole_ff <= mean_whole_in;
         prior_ff <= prior_in;
         rising_ff <= rising_in;
         run_active_ff <= run_active_in;
         run_mode_ff <= run_mode_in;
         run_limit_ff <= run_limit_in;
         sample_count_ff <= sample_count_in;
         idle_left_ff <= idle_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/core/ampd_checker.sv =====
module ampd_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  ampd_pkg::rsp_type                     rsp_data
);

   // every taken request yields a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("response missing after request");

   // an empty response register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // period count only with edge or gap status
   a_periods_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ampd_pkg::ST_EDGE &&
      rsp_data.status != ampd_pkg::ST_GAP |-> rsp_data.periods == '0)
      else $error("period count with wrong status");

endmodule

bind adc_mean_edge_period_detector ampd_checker u_ampd_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned CAL_RUN = 32;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_AT = 400;
   localparam int unsigned HOLD_CYCLES = 150;

   typedef struct {
      ampd_pkg::req_type req;
      int unsigned copies;
      bit typed;
      ampd_pkg::rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   ampd_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   ampd_pkg::rsp_type rsp_data;
   logic csr_wr_en;
   logic [ampd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ampd_pkg::CSR_DATA_W-1:0] csr_wdata;

   // detector state as predicted
   logic edge_direct;
   logic [ampd_pkg::Q5_W-1:0] dev_q5;
   logic [ampd_pkg::TIMEOUT_W-1:0] idle_reload;
   logic [ampd_pkg::CAL_COUNT_W-1:0] cal_n;
   logic [ampd_pkg::Q5_W-1:0] cal_acc;
   logic [ampd_pkg::SAMPLE_W-1:0] cal_lo;
   logic [ampd_pkg::SAMPLE_W-1:0] cal_hi;
   logic [ampd_pkg::Q5_W-1:0] centre_q5;
   logic [ampd_pkg::SAMPLE_W-1:0] centre;
   logic [ampd_pkg::SAMPLE_W-1:0] last_sample;
   logic rising;
   logic running;
   logic [1:0] mode_now;
   logic [ampd_pkg::COUNT_W-1:0] limit_now;
   logic [ampd_pkg::COUNT_W-1:0] counted;
   logic [ampd_pkg::TIMEOUT_W-1:0] idle_budget;

   ampd_pkg::rsp_type owed_responses[$];
   stim_row_type script[$];
   int unsigned requests_sent;
   int unsigned responses_checked;
   int unsigned mismatches;
   int unsigned cycles;
   bit sender_gaps;

   adc_mean_edge_period_detector dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic ampd_pkg::req_type request(input logic [2:0] action,
                                                 input logic [7:0] sample,
                                                 input logic [15:0] limit,
                                                 input logic [1:0] mode);
      ampd_pkg::req_type r;
      r.action = action;
      r.sample = sample;
      r.max_periods = limit;
      r.count_mode = mode;
      return r;
   endfunction

   function automatic ampd_pkg::rsp_type outcome(input logic [2:0] status,
                                                 input logic [15:0] periods,
                                                 input logic level, input logic [7:0] avg,
                                                 input logic [7:0] lo, input logic [7:0] hi);
      ampd_pkg::rsp_type o;
      o.status = status;
      o.periods = periods;
      o.edge_level = level;
      o.average = avg;
      o.minimum = lo;
      o.maximum = hi;
      return o;
   endfunction

   function automatic stim_row_type row(input ampd_pkg::req_type r, input int unsigned copies,
                                        input bit typed, input ampd_pkg::rsp_type want);
      stim_row_type s;
      s.req = r;
      s.copies = copies;
      s.typed = typed;
      s.want = want;
      return s;
   endfunction

   function automatic logic [7:0] clip(input int v);
      return (v < 0) ? 8'd0 : (v > 255) ? ampd_pkg::SAMPLE_MAX : 8'(v);
   endfunction

   // one loop pass of a count run: sample or idle tick
   function automatic logic [2:0] run_step(input bit has_sample, input logic [7:0] s,
                                           output logic [15:0] found_at);
      int peak;
      int trough;
      int s5;
      int p5;
      bit hit;
      found_at = '0;
      idle_budget = idle_budget - 1'b1;
      if (idle_budget == '0) begin
         running = 1'b0;
         return ampd_pkg::ST_TIMEOUT;
      end
      if (!has_sample)
         return ampd_pkg::ST_NONE;
      counted = counted + 1'b1;
      idle_budget = idle_reload;
      peak = int'(centre_q5) + int'(dev_q5);
      trough = (centre_q5 > dev_q5) ? int'(centre_q5) - int'(dev_q5) : 0;
      s5 = int'(s) * 32;
      p5 = int'(last_sample) * 32;
      hit = 1'b0;
      if (mode_now == ampd_pkg::MODE_GAP) begin
         hit = (s == '0);
      end else if (mode_now == ampd_pkg::MODE_EDGE) begin
         if (!edge_direct)
            hit = rising ? (p5 > peak && s <= last_sample) : (p5 < trough && s >= last_sample);
         else
            hit = rising ? (s5 <= int'(centre_q5) && s5 <= trough) : (s5 >= peak);
         if (hit)
            rising = !rising;
      end
      if (hit) begin
         running = 1'b0;
         found_at = counted;
         return (mode_now == ampd_pkg::MODE_GAP) ? ampd_pkg::ST_GAP : ampd_pkg::ST_EDGE;
      end
      last_sample = s;
      if (counted >= limit_now) begin
         running = 1'b0;
         return ampd_pkg::ST_LIMIT;
      end
      return ampd_pkg::ST_NONE;
   endfunction

   function automatic ampd_pkg::rsp_type next_response(input ampd_pkg::req_type r);
      ampd_pkg::rsp_type o;
      logic [15:0] found;
      o = '0;
      found = '0;
      case (r.action)
         ampd_pkg::ACT_CALIBRATE: begin
            if (cal_n == '0) begin
               cal_lo = ampd_pkg::SAMPLE_MAX;
               cal_hi = '0;
            end
            if (r.sample < cal_lo)
               cal_lo = r.sample;
            if (r.sample > cal_hi)
               cal_hi = r.sample;
            cal_acc = cal_acc + ampd_pkg::Q5_W'(r.sample);
            cal_n = cal_n + 1'b1;
            if (cal_n >= CAL_RUN) begin
               centre_q5 = cal_acc;
               centre = cal_acc[ampd_pkg::Q5_W-1:5];
               last_sample = centre;
               cal_acc = '0;
               cal_n = '0;
               o.status = ampd_pkg::ST_CALIBRATED;
            end
         end
         ampd_pkg::ACT_START: begin
            running = 1'b1;
            mode_now = (r.count_mode == ampd_pkg::MODE_UNUSED) ? ampd_pkg::MODE_WAIT
                                                               : r.count_mode;
            limit_now = r.max_periods;
            counted = '0;
            idle_budget = idle_reload;
         end
         ampd_pkg::ACT_SAMPLE: begin
            if (running)
               o.status = run_step(1'b1, r.sample, found);
         end
         ampd_pkg::ACT_IDLE: begin
            if (running)
               o.status = run_step(1'b0, '0, found);
         end
         ampd_pkg::ACT_RESET_EDGE: begin
            rising = 1'b0;
            last_sample = ampd_pkg::SAMPLE_MAX;
         end
         ampd_pkg::ACT_ABORT: begin
            if (running) begin
               running = 1'b0;
               o.status = ampd_pkg::ST_ABORTED;
            end
         end
         default: ;
      endcase
      o.periods = found;
      o.edge_level = rising;
      o.average = centre;
      o.minimum = cal_lo;
      o.maximum = cal_hi;
      return o;
   endfunction

   task automatic send_request(input ampd_pkg::req_type r, input bit typed = 1'b0,
                               input ampd_pkg::rsp_type want = '0);
      int unsigned gap;
      ampd_pkg::rsp_type predicted;
      gap = sender_gaps ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = next_response(r);
      owed_responses.push_back(typed ? want : predicted);
      requests_sent++;
      if (requests_sent % 64 == 0)
         sender_gaps = ($urandom_range(0, 2) != 0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (responses_checked < requests_sent) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_settings(input logic direct, input logic [12:0] dev,
                                 input logic [16:0] reload);
      csr_wr_en <= 1'b1;
      csr_index <= ampd_pkg::CSR_EDGE_MODE;
      csr_wdata <= ampd_pkg::CSR_DATA_W'(direct);
      @(posedge clock);
      csr_index <= ampd_pkg::CSR_DEVIATION;
      csr_wdata <= ampd_pkg::CSR_DATA_W'(dev);
      @(posedge clock);
      csr_index <= ampd_pkg::CSR_TIMEOUT;
      csr_wdata <= reload;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      edge_direct = direct;
      dev_q5 = dev;
      idle_reload = reload;
   endtask

   function automatic ampd_pkg::req_type random_start();
      int unsigned pick;
      logic [1:0] mode;
      logic [15:0] limit;
      pick = $urandom_range(0, 9);
      mode = (pick < 6) ? ampd_pkg::MODE_EDGE :
             (pick < 8) ? ampd_pkg::MODE_GAP :
             (pick < 9) ? ampd_pkg::MODE_WAIT : ampd_pkg::MODE_UNUSED;
      pick = $urandom_range(0, 9);
      limit = (pick < 7) ? 16'($urandom_range(1, 48)) : (pick < 8) ? 16'd0 :
              (pick < 9) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      return request(ampd_pkg::ACT_START, 8'($urandom_range(0, 255)), limit, mode);
   endfunction

   task automatic run_phase(input int unsigned n);
      int unsigned made;
      int unsigned pick;
      int unsigned len;
      int unsigned half;
      int unsigned burst;
      int amp;
      int mid;
      int spread;
      bit wild;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            mid = $urandom_range(0, 255);
            spread = $urandom_range(0, 60);
            wild = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < CAL_RUN; k++) begin
               send_request(request(ampd_pkg::ACT_CALIBRATE,
                  wild ? 8'($urandom_range(0, 255))
                       : clip(mid + int'($urandom_range(0, 2 * spread)) - spread),
                  16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3))));
               made++;
            end
         end else if (pick < 9) begin
            send_request(random_start());
            made++;
            len = $urandom_range(1, 40);
            amp = $urandom_range(0, 127);
            half = $urandom_range(1, 6);
            mid = int'(centre) + int'($urandom_range(0, 20)) - 10;
            for (int k = 0; k < len; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 72) begin
                  send_request(request(ampd_pkg::ACT_SAMPLE,
                     clip(mid + (((k / half) % 2 != 0) ? amp : -amp)
                          + int'($urandom_range(0, 6)) - 3), '0, '0));
               end else if (pick < 82) begin
                  burst = $urandom_range(1, 8);
                  repeat (burst)
                     send_request(request(ampd_pkg::ACT_IDLE, '0, '0, '0));
                  made += burst - 1;
               end else if (pick < 86) begin
                  send_request(request(ampd_pkg::ACT_SAMPLE, '0, '0, '0));
               end else if (pick < 89) begin
                  send_request(request(ampd_pkg::ACT_RESET_EDGE, '0, '0, '0));
               end else if (pick < 91) begin
                  send_request(request(ampd_pkg::ACT_ABORT, '0, '0, '0));
               end else if (pick < 94) begin
                  send_request(request(ampd_pkg::ACT_CALIBRATE, 8'($urandom_range(0, 255)),
                                       '0, '0));
               end else if (pick < 97) begin
                  send_request(random_start());
               end else begin
                  send_request(request(ampd_pkg::ACT_SAMPLE, 8'($urandom_range(0, 255)),
                                       '0, '0));
               end
               made++;
            end
         end else begin
            burst = $urandom_range(1, 4);
            repeat (burst)
               send_request(request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                    16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3))));
            made += burst;
         end
      end
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin : response_check
      ampd_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d periods %0d edge %0d mean %0d",
                        rsp_data.status, rsp_data.periods, rsp_data.edge_level,
                        rsp_data.average);
         end else begin
            want = owed_responses.pop_front();
            responses_checked++;
            if (rsp_data.status !== want.status || rsp_data.periods !== want.periods ||
                rsp_data.edge_level !== want.edge_level || rsp_data.average !== want.average ||
                rsp_data.minimum !== want.minimum || rsp_data.maximum !== want.maximum) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected %0d/%0d/%0d/%0d/%0d/%0d",
                           responses_checked, want.status, want.periods, want.edge_level,
                           want.average, want.minimum, want.maximum,
                           " got %0d/%0d/%0d/%0d/%0d/%0d", rsp_data.status,
                           rsp_data.periods, rsp_data.edge_level, rsp_data.average,
                           rsp_data.minimum, rsp_data.maximum);
            end
         end
      end
   end

   initial begin : response_sink
      int unsigned stall;
      int unsigned taken;
      bit stalls_on;
      bit held;
      taken = 0;
      stalls_on = 1'b1;
      held = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (taken == HOLD_AT && !held) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else begin
            stall = stalls_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
         if (taken % 48 == 0)
            stalls_on = ($urandom_range(0, 2) != 0);
      end
   end

   initial begin : stimulus
      ampd_pkg::rsp_type quiet;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = ampd_pkg::CSR_EDGE_MODE;
      csr_wdata = '0;
      requests_sent = 0;
      responses_checked = 0;
      mismatches = 0;
      cycles = 0;
      sender_gaps = 1'b1;

      edge_direct = 1'b0;
      dev_q5 = ampd_pkg::DEVIATION_RESET;
      idle_reload = ampd_pkg::TIMEOUT_RESET;
      cal_n = '0;
      cal_acc = '0;
      cal_lo = ampd_pkg::SAMPLE_MAX;
      cal_hi = '0;
      centre_q5 = '0;
      centre = '0;
      last_sample = '0;
      rising = 1'b0;
      running = 1'b0;
      mode_now = ampd_pkg::MODE_EDGE;
      limit_now = '0;
      counted = '0;
      idle_budget = ampd_pkg::TIMEOUT_RESET;

      quiet = outcome(ampd_pkg::ST_NONE, '0, 1'b0, '0, ampd_pkg::SAMPLE_MAX, '0);
      script.push_back(row(request(ampd_pkg::ACT_SAMPLE, ampd_pkg::SAMPLE_MAX, '0,
                                   ampd_pkg::MODE_EDGE), 1, 1'b1, quiet));
      script.push_back(row(request(ampd_pkg::ACT_IDLE, '0, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b1, quiet));
      script.push_back(row(request(ampd_pkg::ACT_ABORT, '0, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b1, quiet));
      script.push_back(row(request(ampd_pkg::ACT_SPARE_LOW, ampd_pkg::SAMPLE_MAX, 16'hFFFF,
                                   ampd_pkg::MODE_UNUSED), 1, 1'b1, quiet));
      script.push_back(row(request(ampd_pkg::ACT_SPARE_HIGH, '0, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b1, quiet));
      script.push_back(row(request(ampd_pkg::ACT_RESET_EDGE, '0, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b1, quiet));
      script.push_back(row(request(ampd_pkg::ACT_CALIBRATE, '0, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b1, outcome(ampd_pkg::ST_NONE, '0, 1'b0, '0, '0, '0)));
      script.push_back(row(request(ampd_pkg::ACT_CALIBRATE, '0, '0, ampd_pkg::MODE_EDGE),
                           15, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_CALIBRATE, ampd_pkg::SAMPLE_MAX, '0,
                                   ampd_pkg::MODE_EDGE), 15, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_CALIBRATE, ampd_pkg::SAMPLE_MAX, '0,
                                   ampd_pkg::MODE_EDGE), 1, 1'b1,
                           outcome(ampd_pkg::ST_CALIBRATED, '0, 1'b0, 8'd127, '0,
                                   ampd_pkg::SAMPLE_MAX)));
      script.push_back(row(request(ampd_pkg::ACT_START, '0, 16'hFFFF, ampd_pkg::MODE_EDGE),
                           1, 1'b1,
                           outcome(ampd_pkg::ST_NONE, '0, 1'b0, 8'd127, '0,
                                   ampd_pkg::SAMPLE_MAX)));
      script.push_back(row(request(ampd_pkg::ACT_SAMPLE, 8'd100, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_SAMPLE, 8'd101, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_START, '0, '0, ampd_pkg::MODE_GAP),
                           1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_SAMPLE, '0, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b1,
                           outcome(ampd_pkg::ST_GAP, 16'd1, 1'b1, 8'd127, '0,
                                   ampd_pkg::SAMPLE_MAX)));
      script.push_back(row(request(ampd_pkg::ACT_START, '0, '0, ampd_pkg::MODE_WAIT),
                           1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_SAMPLE, 8'd200, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b1,
                           outcome(ampd_pkg::ST_LIMIT, '0, 1'b1, 8'd127, '0,
                                   ampd_pkg::SAMPLE_MAX)));
      script.push_back(row(request(ampd_pkg::ACT_START, '0, 16'd2, ampd_pkg::MODE_UNUSED),
                           1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_IDLE, '0, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_START, '0, 16'd3, ampd_pkg::MODE_EDGE),
                           1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_RESET_EDGE, '0, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_SAMPLE, ampd_pkg::SAMPLE_MAX, '0,
                                   ampd_pkg::MODE_EDGE), 1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_SAMPLE, 8'd250, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b0, '0));
      script.push_back(row(request(ampd_pkg::ACT_ABORT, '0, '0, ampd_pkg::MODE_EDGE),
                           1, 1'b1,
                           outcome(ampd_pkg::ST_ABORTED, '0, 1'b0, 8'd127, '0,
                                   ampd_pkg::SAMPLE_MAX)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         repeat (script[i].copies)
            send_request(script[i].req, script[i].typed, script[i].want);

      for (int p = 0; p < 7; p++) begin
         settle();
         case (p)
            0: write_settings(1'b1, 13'd640, 17'd6);
            1: write_settings(1'b0, 13'd0, 17'd4);
            2: write_settings(1'b1, 13'd8160, 17'd131071);
            3: write_settings(1'b0, 13'd8160, 17'd1);
            4: write_settings(1'b1, 13'd0, 17'd0);
            5: write_settings(1'b0, 13'($urandom_range(0, 1200)), 17'($urandom_range(2, 12)));
            default: write_settings(1'b1, 13'($urandom_range(0, 8191)),
                                    17'($urandom_range(2, 12)));
         endcase
         run_phase((p == 3) ? 50 : 120);
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
